>>> sv/ssg_pkg.sv
// Shared types, constants and helpers of the staggered surface gradient unit.
`default_nettype none
package ssg_pkg;
   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W     = 16;
   localparam int GW_W      = 11;
   localparam int DATA_W    = 32;
   localparam int CELL_W    = 3 * DATA_W;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * DATA_W - 1;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd4;

   localparam logic [DATA_W-1:0] INV_RESET = 32'd65536;
   localparam logic [GW_W-1:0]   GW_RESET  = 11'd1024;
   localparam logic [ROW_W-1:0]  GH_RESET  = 16'd1024;

   typedef struct packed {
      logic signed [DATA_W-1:0] s;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] t;
   } cell_type;

   // south-west corner is never used by the stencil
   typedef struct packed {
      cell_type nw;
      cell_type n;
      cell_type ne;
      cell_type w;
      cell_type p;
      cell_type e;
      cell_type s;
      cell_type se;
   } window_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctrl_type;

   typedef struct packed {
      logic              mode;
      logic [DATA_W-1:0] inv_dx;
      logic [DATA_W-1:0] inv_dy;
      logic [WCNT_W-1:0] width;
      logic [ROW_W-1:0]  height;
   } cfg_type;

   // pseudo-surface of a neighbour seen from a reference cell
   function automatic logic signed [DATA_W-1:0] pseudo(input cell_type nb, input cell_type rc,
                                                       input logic mode);
      logic signed [DATA_W-1:0] v;
      v = nb.s;
      if (mode) begin
         if (nb.t <= 0 && nb.b > rc.s) v = rc.s;
         if (rc.t <= 0 && rc.b > nb.s) v = rc.s;
      end
      return v;
   endfunction

   // signed saturation of a scaled magnitude
   function automatic logic [DATA_W-1:0] sat_q16(input logic [PROD_W-1:0] prod, input logic neg,
                                                 input logic big, input logic zero);
      logic [DATA_W:0] p;
      logic [DATA_W-1:0] r;
      p = big ? {1'b1, {DATA_W{1'b0}}} : {1'b0, {DATA_W{1'b0}}};
      if (zero) begin
         r = '0;
      end else if (big || prod[PROD_W-1:DATA_W-1] != '0) begin
         r = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = neg ? (~prod[DATA_W-1:0] + 1'b1) : prod[DATA_W-1:0];
      end
      return r | p[DATA_W-1:0];
   endfunction
endpackage
`default_nettype wire

>>> sv/staggered_surface_gradient_unit.sv
// Top level of the staggered surface gradient unit.
//  channel | ports  | beat
//  input   | req_*  | one grid cell, raster order, x fastest
//  result  | rsp_*  | slopes of one interior cell
//  config  | csr_*  | register write, no handshake
// A result passes the input and line store read registers, the window, difference, product and saturation registers.
// One beat per cycle sustained while no result is stalled.
// Pipeline: line store read, window shift, differences, multiply, saturate.
// A stalled result holds the whole pipeline; ready is low only then and during reset.
// Reset clears counters and control and loads register defaults; line stores need no clearing.
`default_nettype none
module staggered_surface_gradient_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [ssg_pkg::DATA_W-1:0] req_surface,
   input  wire logic signed [ssg_pkg::DATA_W-1:0] req_bed,
   input  wire logic signed [ssg_pkg::DATA_W-1:0] req_thick,
   input  wire logic                              req_first_of_grid,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [ssg_pkg::DATA_W-1:0]      rsp_grad_x_east,
   output logic signed [ssg_pkg::DATA_W-1:0]      rsp_grad_y_east,
   output logic signed [ssg_pkg::DATA_W-1:0]      rsp_grad_x_north,
   output logic signed [ssg_pkg::DATA_W-1:0]      rsp_grad_y_north,
   output logic                                   rsp_end_of_grid,
   input  wire logic                              csr_we,
   input  wire logic [ssg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ssg_pkg::DATA_W-1:0]        csr_wdata
);
   logic                       mode_ff;
   logic [ssg_pkg::DATA_W-1:0] inv_dx_ff, inv_dy_ff;
   logic [ssg_pkg::GW_W-1:0]   gw_ff;
   logic [ssg_pkg::ROW_W-1:0]  gh_ff;
   ssg_pkg::cfg_type           cfg;
   ssg_pkg::cell_type          nc;
   ssg_pkg::window_type        win;
   ssg_pkg::ctrl_type          ctrl;
   logic                       adv, accept;
   logic [ssg_pkg::DATA_W-1:0] xe, ye, xn, yn;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         inv_dx_ff <= ssg_pkg::INV_RESET;
         inv_dy_ff <= ssg_pkg::INV_RESET;
         gw_ff     <= ssg_pkg::GW_RESET;
         gh_ff     <= ssg_pkg::GH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ssg_pkg::CSR_MODE:   mode_ff   <= csr_wdata[0];
            ssg_pkg::CSR_INV_DX: inv_dx_ff <= csr_wdata;
            ssg_pkg::CSR_INV_DY: inv_dy_ff <= csr_wdata;
            ssg_pkg::CSR_WIDTH:  gw_ff     <= csr_wdata[ssg_pkg::GW_W-1:0];
            ssg_pkg::CSR_HEIGHT: gh_ff     <= csr_wdata[ssg_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.mode   = mode_ff;
      cfg.inv_dx = inv_dx_ff;
      cfg.inv_dy = inv_dy_ff;
      if (32'(gw_ff) < 3)                       cfg.width = ssg_pkg::WCNT_W'(3);
      else if (32'(gw_ff) > ssg_pkg::MAX_WIDTH) cfg.width = ssg_pkg::WCNT_W'(ssg_pkg::MAX_WIDTH);
      else                                      cfg.width = ssg_pkg::WCNT_W'(gw_ff);
      cfg.height = (gh_ff < 3) ? ssg_pkg::ROW_W'(3) : gh_ff;
      nc.s = req_surface;
      nc.b = req_bed;
      nc.t = req_thick;
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv && !reset;
   assign accept    = req_valid && req_ready;

   ssg_stencil u_stencil (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .accept (accept),
      .nc_in  (nc),
      .first  (req_first_of_grid),
      .cfg    (cfg),
      .win    (win),
      .ctrl   (ctrl)
   );

   ssg_slope u_slope (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .win       (win),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_xe    (xe),
      .out_ye    (ye),
      .out_xn    (xn),
      .out_yn    (yn),
      .out_last  (rsp_end_of_grid)
   );

   assign rsp_grad_x_east  = xe;
   assign rsp_grad_y_east  = ye;
   assign rsp_grad_x_north = xn;
   assign rsp_grad_y_north = yn;
endmodule
`default_nettype wire

>>> sv/ssg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

>>> sv/ssg_stencil.sv
// Position counters, two line stores and the 3x3 neighbour window.
`default_nettype none
module ssg_stencil (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              accept,
   input  wire ssg_pkg::cell_type nc_in,
   input  wire logic              first,
   input  wire ssg_pkg::cfg_type  cfg,
   output ssg_pkg::window_type    win,
   output ssg_pkg::ctrl_type      ctrl
);
   logic [ssg_pkg::ADDR_W-1:0] col_ff, col_in, c;
   logic [ssg_pkg::ROW_W-1:0]  row_ff, row_in, r;
   logic [ssg_pkg::WCNT_W-1:0] c_ext;
   logic [ssg_pkg::ROW_W:0]    r_inc;
   logic                       emit, last;

   logic                       a_valid_ff, a_emit_ff, a_last_ff;
   ssg_pkg::cell_type          a_cell_ff;
   logic [ssg_pkg::ADDR_W-1:0] a_col_ff;

   logic                       we;
   logic [ssg_pkg::CELL_W-1:0] up_rd, lo_rd;
   ssg_pkg::cell_type          up_eff, lo_eff, fwd_up_ff, fwd_lo_ff;
   logic                       fwd_ff;

   ssg_pkg::window_type        win_ff;
   ssg_pkg::ctrl_type          ctrl_ff;

   always_comb begin
      c     = first ? '0 : col_ff;
      r     = first ? '0 : row_ff;
      c_ext = ssg_pkg::WCNT_W'(c);
      r_inc = {1'b0, r} + 1'b1;
      emit  = c >= 2 && r >= 2 && c_ext < cfg.width && r < cfg.height;
      last  = c_ext == cfg.width - 1'b1 && r == cfg.height - 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_ext + 1'b1 >= cfg.width) begin
            col_in = '0;
            row_in = (r_inc >= {1'b0, cfg.height}) ? '0 : r_inc[ssg_pkg::ROW_W-1:0];
         end else begin
            col_in = c + 1'b1;
            row_in = r;
         end
      end
   end

   assign we     = adv && a_valid_ff;
   assign up_eff = fwd_ff ? fwd_up_ff : ssg_pkg::cell_type'(up_rd);
   assign lo_eff = fwd_ff ? fwd_lo_ff : ssg_pkg::cell_type'(lo_rd);

   ssg_ram #(.WIDTH(ssg_pkg::CELL_W), .DEPTH(ssg_pkg::MAX_WIDTH)) u_upper (
      .clock (clock),
      .we    (we),
      .waddr (a_col_ff),
      .wdata (a_cell_ff),
      .re    (accept),
      .raddr (c),
      .rdata (up_rd)
   );

   ssg_ram #(.WIDTH(ssg_pkg::CELL_W), .DEPTH(ssg_pkg::MAX_WIDTH)) u_lower (
      .clock (clock),
      .we    (we),
      .waddr (a_col_ff),
      .wdata (up_eff),
      .re    (accept),
      .raddr (c),
      .rdata (lo_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
         ctrl_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (adv) begin
            a_valid_ff <= accept;
            ctrl_ff.valid <= a_valid_ff && a_emit_ff;
            ctrl_ff.last  <= a_last_ff;
         end
         // read and write of the same entry at one edge: take the new data
         if (accept) fwd_ff <= we && a_col_ff == c;
      end
      if (accept) begin
         a_cell_ff <= nc_in;
         a_col_ff  <= c;
         a_emit_ff <= emit;
         a_last_ff <= last;
         fwd_up_ff <= a_cell_ff;
         fwd_lo_ff <= up_eff;
      end
      if (we) begin
         win_ff.nw <= win_ff.n;
         win_ff.w  <= win_ff.p;
         win_ff.n  <= win_ff.ne;
         win_ff.p  <= win_ff.e;
         win_ff.s  <= win_ff.se;
         win_ff.ne <= a_cell_ff;
         win_ff.e  <= up_eff;
         win_ff.se <= lo_eff;
      end
   end

   assign win  = win_ff;
   assign ctrl = ctrl_ff;
endmodule
`default_nettype wire

>>> sv/ssg_slope.sv
// Differences, scaling by reciprocal spacing and Q16 saturation.
`default_nettype none
module ssg_slope (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire ssg_pkg::window_type        win,
   input  wire ssg_pkg::ctrl_type          ctrl,
   input  wire ssg_pkg::cfg_type           cfg,
   output logic                            out_valid,
   output logic [ssg_pkg::DATA_W-1:0]      out_xe,
   output logic [ssg_pkg::DATA_W-1:0]      out_ye,
   output logic [ssg_pkg::DATA_W-1:0]      out_xn,
   output logic [ssg_pkg::DATA_W-1:0]      out_yn,
   output logic                            out_last
);
   localparam int SUM_W = ssg_pkg::DATA_W + 3;

   logic signed [ssg_pkg::DATA_W-1:0] h_e, h_n, h_s, h_w, e_ne, e_se, n_ne, n_nw;
   logic signed [SUM_W-1:0]           sum_e, sum_n;
   logic signed [ssg_pkg::DIFF_W-1:0] d_in [4];
   logic signed [ssg_pkg::DIFF_W-1:0] d_ff [4];
   ssg_pkg::ctrl_type                 d_ctrl_ff, p_ctrl_ff;

   logic [ssg_pkg::DATA_W-1:0]        k [4];
   logic [ssg_pkg::DIFF_W-1:0]        mag [4];
   logic [ssg_pkg::PROD_W-1:0]        prod_ff [4];
   logic [3:0]                        neg_ff, big_ff, zero_ff;
   logic [ssg_pkg::DATA_W-1:0]        res_ff [4];
   logic                              valid_ff, last_ff;

   always_comb begin
      h_e  = ssg_pkg::pseudo(win.e,  win.p, cfg.mode);
      h_n  = ssg_pkg::pseudo(win.n,  win.p, cfg.mode);
      h_s  = ssg_pkg::pseudo(win.s,  win.p, cfg.mode);
      h_w  = ssg_pkg::pseudo(win.w,  win.p, cfg.mode);
      e_ne = ssg_pkg::pseudo(win.ne, win.e, cfg.mode);
      e_se = ssg_pkg::pseudo(win.se, win.e, cfg.mode);
      n_ne = ssg_pkg::pseudo(win.ne, win.n, cfg.mode);
      n_nw = ssg_pkg::pseudo(win.nw, win.n, cfg.mode);
      sum_e = SUM_W'(e_ne) + SUM_W'(h_n) - SUM_W'(e_se) - SUM_W'(h_s);
      sum_n = SUM_W'(n_ne) + SUM_W'(h_e) - SUM_W'(n_nw) - SUM_W'(h_w);
      d_in[0] = ssg_pkg::DIFF_W'(h_e) - ssg_pkg::DIFF_W'(win.p.s);
      d_in[1] = sum_e[SUM_W-1:2];   // floor divide by 4
      d_in[2] = sum_n[SUM_W-1:2];
      d_in[3] = ssg_pkg::DIFF_W'(h_n) - ssg_pkg::DIFF_W'(win.p.s);
      k[0] = cfg.inv_dx;
      k[1] = cfg.inv_dy;
      k[2] = cfg.inv_dx;
      k[3] = cfg.inv_dy;
      for (int i = 0; i < 4; i++) begin
         mag[i] = d_ff[i][ssg_pkg::DIFF_W-1] ? ssg_pkg::DIFF_W'(-d_ff[i])
                                              : ssg_pkg::DIFF_W'(d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctrl_ff <= '0;
         p_ctrl_ff <= '0;
         valid_ff  <= 1'b0;
      end else if (adv) begin
         d_ctrl_ff <= ctrl;
         p_ctrl_ff <= d_ctrl_ff;
         valid_ff  <= p_ctrl_ff.valid;
      end
      if (adv) begin
         last_ff <= p_ctrl_ff.last;
         for (int i = 0; i < 4; i++) begin
            d_ff[i]    <= d_in[i];
            prod_ff[i] <= mag[i][ssg_pkg::DATA_W-2:0] * k[i];
            neg_ff[i]  <= d_ff[i][ssg_pkg::DIFF_W-1];
            big_ff[i]  <= mag[i][ssg_pkg::DIFF_W-1:ssg_pkg::DATA_W-1] != '0;
            zero_ff[i] <= k[i] == '0 || mag[i] == '0;
            res_ff[i]  <= ssg_pkg::sat_q16(prod_ff[i], neg_ff[i], big_ff[i], zero_ff[i]);
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_last  = last_ff;
   assign out_xe    = res_ff[0];
   assign out_ye    = res_ff[1];
   assign out_xn    = res_ff[2];
   assign out_yn    = res_ff[3];
endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the staggered surface gradient unit.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssg_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int N_DIRECTED  = 27;
   localparam int N_PHASES    = 7;

   typedef struct {
      logic [DATA_W-1:0] gxe;
      logic [DATA_W-1:0] gye;
      logic [DATA_W-1:0] gxn;
      logic [DATA_W-1:0] gyn;
      logic              eog;
   } grad_set;

   typedef struct {
      cell_type pt;
      bit       first;
      bit       typed;
      grad_set  want;
   } dir_row;

   typedef struct {
      logic        mode;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] w;
      logic [31:0] h;
      int          ncells;
   } grid_setup;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [DATA_W-1:0] req_surface = 0, req_bed = 0, req_thick = 0;
   logic req_first_of_grid = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [DATA_W-1:0] rsp_grad_x_east, rsp_grad_y_east, rsp_grad_x_north;
   logic signed [DATA_W-1:0] rsp_grad_y_north;
   logic rsp_end_of_grid;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODE;
   logic [DATA_W-1:0] csr_wdata = 0;

   staggered_surface_gradient_unit u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // shadow of the block's registers and state
   logic              cur_mode;
   logic [DATA_W-1:0] cur_dx, cur_dy;
   logic [GW_W-1:0]   cur_w;
   logic [ROW_W-1:0]  cur_h;
   int                col_pos, row_pos;
   cell_type          line_up [MAX_WIDTH];
   cell_type          line_lo [MAX_WIDTH];
   cell_type          win [3][3];   // [south, mid, north][west, mid, east]

   grad_set pending_grads[$];
   int fails = 0, in_beats = 0, out_beats = 0, burst_left = 0;

   function automatic longint surf_seen(cell_type nb, cell_type rc);
      longint v;
      v = nb.s;
      if (cur_mode) begin
         if (nb.t <= 0 && nb.b > rc.s) v = rc.s;
         if (rc.t <= 0 && rc.b > nb.s) v = rc.s;
      end
      return v;
   endfunction

   function automatic logic [31:0] slope_q16(longint d, logic [31:0] k);
      longint unsigned mag, p;
      mag = (d < 0) ? -d : d;
      if (k == 0 || mag == 0) return 0;
      p = (mag >= 64'h8000_0000) ? 64'h1_0000_0000 : mag * k;
      if (d < 0) return (p >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-p);
      return (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
   endfunction

   function automatic int eff_width(logic [GW_W-1:0] w);
      return (w < 3) ? 3 : ((w > MAX_WIDTH) ? MAX_WIDTH : int'(w));
   endfunction

   function automatic void advance_gradient(cell_type nc, bit first);
      int w, h, c, r;
      cell_type up, lo;
      longint hE, hN, hS, hW, eNE, eSE, nNE, nNW, ps;
      grad_set g;
      w = eff_width(cur_w);
      h = (cur_h < 3) ? 3 : int'(cur_h);
      if (first) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      up = '0;
      lo = '0;
      if (c < MAX_WIDTH) begin
         up = line_up[c];
         lo = line_lo[c];
         line_lo[c] = up;
         line_up[c] = nc;
      end
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = lo;
      win[1][2] = up;
      win[2][2] = nc;
      if (c >= 2 && r >= 2 && c < w && r < h) begin
         ps  = win[1][1].s;
         hE  = surf_seen(win[1][2], win[1][1]);
         hN  = surf_seen(win[2][1], win[1][1]);
         hS  = surf_seen(win[0][1], win[1][1]);
         hW  = surf_seen(win[1][0], win[1][1]);
         eNE = surf_seen(win[2][2], win[1][2]);
         eSE = surf_seen(win[0][2], win[1][2]);
         nNE = surf_seen(win[2][2], win[2][1]);
         nNW = surf_seen(win[2][0], win[2][1]);
         g.gxe = slope_q16(hE - ps, cur_dx);
         g.gye = slope_q16((eNE + hN - eSE - hS) >>> 2, cur_dy);
         g.gxn = slope_q16((nNE + hE - nNW - hW) >>> 2, cur_dx);
         g.gyn = slope_q16(hN - ps, cur_dy);
         g.eog = (c == w - 1 && r == h - 1);
         pending_grads.push_back(g);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic cell_type rand_cell();
      cell_type c;
      logic [31:0] edges [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      case ($urandom_range(0, 9))
         0: begin
            c.s = $urandom; c.b = $urandom; c.t = $urandom;
         end
         1: begin
            c.s = edges[$urandom_range(0, 3)];
            c.b = edges[$urandom_range(0, 3)];
            c.t = edges[$urandom_range(0, 3)];
         end
         default: begin
            c.s = int'($urandom_range(0, 4000)) - 2000;
            c.b = c.s + int'($urandom_range(0, 600)) - 300;
            c.t = $urandom_range(0, 1) ? -int'($urandom_range(0, 50))
                                       : int'($urandom_range(1, 5000));
         end
      endcase
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MODE:   cur_mode = data[0];
         CSR_INV_DX: cur_dx   = data;
         CSR_INV_DY: cur_dy   = data;
         CSR_WIDTH:  cur_w    = data[GW_W-1:0];
         CSR_HEIGHT: cur_h    = data[ROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic setup_grid(grid_setup p);
      write_reg(CSR_MODE, {31'd0, p.mode});
      write_reg(CSR_INV_DX, p.dx);
      write_reg(CSR_INV_DY, p.dy);
      write_reg(CSR_WIDTH, p.w);
      write_reg(CSR_HEIGHT, p.h);
      @(negedge clock);
      csr_we <= 0;
   endtask

   // one input beat, with bursty gaps between groups of beats
   task automatic send_cell(cell_type c, bit first);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1;
      req_surface       <= c.s;
      req_bed           <= c.b;
      req_thick         <= c.t;
      req_first_of_grid <= first;
      do @(posedge clock); while (!req_ready);
      advance_gradient(c, first);
      in_beats++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      wait (pending_grads.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      grad_set w;
      if (!reset && rsp_valid && rsp_ready) begin
         out_beats++;
         if (pending_grads.size() == 0) begin
            $error("result beat with nothing pending");
            fails++;
         end else begin
            w = pending_grads.pop_front();
            check_field("grad_x_east", w.gxe, rsp_grad_x_east);
            check_field("grad_y_east", w.gye, rsp_grad_y_east);
            check_field("grad_x_north", w.gxn, rsp_grad_x_north);
            check_field("grad_y_north", w.gyn, rsp_grad_y_north);
            check_field("end_of_grid", {31'd0, w.eog}, {31'd0, rsp_end_of_grid});
         end
      end
   end

   // receiver: changing stall styles, plus one long hold to back up the pipe
   initial begin
      int style, hold;
      bit held;
      style = 0;
      hold = 0;
      held = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) style = $urandom_range(0, 3);
         if (!held && in_beats >= 150) begin
            held = 1;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else begin
            case (style)
               0: rsp_ready <= 1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 9) < 4);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      dir_row    dir [N_DIRECTED];
      grid_setup plan [N_PHASES];
      grad_set   g;
      int        gsize;
      bit        first;
      cell_type  c;

      cur_mode = 0;
      cur_dx   = INV_RESET;
      cur_dy   = INV_RESET;
      cur_w    = GW_RESET;
      cur_h    = GH_RESET;
      col_pos  = 0;
      row_pos  = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_up[i] = '0;
         line_lo[i] = '0;
      end
      win = '{default: '0};

      // three 3x3 grids, ice everywhere, only the east neighbour's surface differs
      for (int i = 0; i < N_DIRECTED; i++) begin
         dir[i].pt    = '{s: 0, b: -100, t: 500};
         dir[i].first = (i % 9 == 0);
         dir[i].typed = 0;
         dir[i].want  = '{default: '0};
      end
      dir[5].pt.s  = 1;
      dir[14].pt.s = 32'h7FFF_FFFF;
      dir[23].pt.s = 32'h8000_0000;
      dir[8].typed  = 1;
      dir[8].want   = '{gxe: 32'd65536, gye: 0, gxn: 0, gyn: 0, eog: 1};
      dir[17].typed = 1;
      dir[17].want  = '{gxe: 32'h7FFF_FFFF, gye: 0, gxn: 32'h7FFF_FFFF, gyn: 0, eog: 1};
      dir[26].typed = 1;
      dir[26].want  = '{gxe: 32'h8000_0000, gye: 0, gxn: 32'h8000_0000, gyn: 0, eog: 1};

      plan[0] = '{1, 65536, 65536, 5, 4, 120};
      plan[1] = '{0, 1, 32'hFFFF_FFFF, 0, 0, 90};
      plan[2] = '{1, 0, 12345, 7, 5, 140};
      plan[3] = '{1, 32'hFFFF_FFFF, 1, 9, 3, 60};
      plan[4] = '{0, 300, 70000, 4, 65535, 32};
      plan[5] = '{1, 65536, 65536, 6, 6, 120};
      plan[6] = '{0, 65536, 65536, 3, 3, 27};

      repeat (6) @(posedge clock);
      reset <= 0;

      setup_grid('{0, 65536, 65536, 3, 3, 0});
      foreach (dir[i]) begin
         send_cell(dir[i].pt, dir[i].first);
         if (dir[i].typed) begin
            g = pending_grads.pop_back();
            pending_grads.push_back(dir[i].want);
         end
      end
      drain();

      foreach (plan[p]) begin
         setup_grid(plan[p]);
         gsize = eff_width(plan[p].w[GW_W-1:0]) *
                 ((plan[p].h[ROW_W-1:0] < 3) ? 3 : int'(plan[p].h[ROW_W-1:0]));
         for (int k = 0; k < plan[p].ncells; k++) begin
            // occasional stray grid start breaks the raster
            first = (k % gsize == 0) || ($urandom_range(0, 249) == 0);
            c = rand_cell();
            send_cell(c, first);
         end
         drain();
      end

      $display("Sent %0d cells over %0d register settings, checked %0d gradient results.",
               in_beats, N_PHASES + 1, out_beats);
      $display("Both stencil modes, saturation and width/height clamps were exercised.");
      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
sv/ssg_pkg.sv
sv/ssg_ram.sv
sv/ssg_stencil.sv
sv/ssg_slope.sv
sv/staggered_surface_gradient_unit.sv
bench/tb.sv
